// ----- hdl/mode_banked_register_file_top_defines.svh -----
// ----------------------------------------------------------------------------
// Mode-banked register file assertion macros
// Shared concurrent assertion forms, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef MODE_BANKED_REGISTER_FILE_TOP_DEFINES_SVH
`define MODE_BANKED_REGISTER_FILE_TOP_DEFINES_SVH

// checked outside reset only
`define MBRF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset too
`define MBRF_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/mbrf_pkg.sv -----
// ----------------------------------------------------------------------------
// Mode-banked register file package
// Action and mode codes, memory map, decode struct and FSM states.
// ----------------------------------------------------------------------------
package mbrf_pkg;

   localparam int DATA_W    = 32;
   localparam int MEM_DEPTH = 36;
   localparam int MEM_AW    = 6;

   localparam logic [2:0] ACT_READ_REG    = 3'd0;
   localparam logic [2:0] ACT_WRITE_REG   = 3'd1;
   localparam logic [2:0] ACT_READ_STAT   = 3'd2;
   localparam logic [2:0] ACT_WRITE_STAT  = 3'd3;
   localparam logic [2:0] ACT_READ_SAVED  = 3'd4;
   localparam logic [2:0] ACT_WRITE_SAVED = 3'd5;

   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   localparam logic [2:0] BANK_USR  = 3'd0;
   localparam logic [2:0] BANK_FIQ  = 3'd1;
   localparam logic [2:0] BANK_IRQ  = 3'd2;
   localparam logic [2:0] BANK_SVC  = 3'd3;
   localparam logic [2:0] BANK_ABT  = 3'd4;
   localparam logic [2:0] BANK_UND  = 3'd5;
   localparam logic [2:0] BANK_NONE = 3'd7;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [3:0] SHARED_LOW = 4'd8;
   localparam logic [3:0] REG_PC     = 4'd15;
   localparam logic [MEM_AW-1:0] FIQ_BASE    = 6'd16;
   localparam logic [MEM_AW-1:0] BANKED_BASE = 6'd23;
   localparam logic [MEM_AW-1:0] SAVED_BASE  = 6'd31;

   typedef struct packed {
      logic [MEM_AW-1:0] addr;
      logic              err;
      logic              rd_mem;
      logic              wr_mem;
      logic              rd_status;
      logic              wr_status;
      logic [DATA_W-1:0] mask;
   } decode_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

endpackage

// ----- hdl/mbrf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mbrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/mbrf_decode.sv -----
// ----------------------------------------------------------------------------
// Mode-banked register file access decoder
// Maps action, register number and mode to a memory entry and size mask.
// ----------------------------------------------------------------------------
module mbrf_decode (
   input  logic [2:0]          action,
   input  logic [3:0]          reg_index,
   input  logic [1:0]          access_size,
   input  logic [4:0]          mode,
   output mbrf_pkg::decode_type dec
);
   import mbrf_pkg::*;

   logic [2:0]        bank;
   logic [MEM_AW-1:0] phys;
   logic              phys_err;
   logic [1:0]        bank_off;

   always_comb begin
      case (mode)
         MODE_USR: bank = BANK_USR;
         MODE_SYS: bank = BANK_USR;
         MODE_FIQ: bank = BANK_FIQ;
         MODE_IRQ: bank = BANK_IRQ;
         MODE_SVC: bank = BANK_SVC;
         MODE_ABT: bank = BANK_ABT;
         MODE_UND: bank = BANK_UND;
         default:  bank = BANK_NONE;
      endcase
   end

   always_comb begin
      bank_off = 2'(bank - BANK_IRQ);
      phys_err = 1'b0;
      phys     = {2'b00, reg_index};
      if (reg_index < SHARED_LOW) begin
         phys = {2'b00, reg_index};
      end else if (bank == BANK_NONE) begin
         phys_err = 1'b1;
      end else if (reg_index == REG_PC || bank == BANK_USR) begin
         phys = {2'b00, reg_index};
      end else if (bank == BANK_FIQ) begin
         phys = FIQ_BASE + {3'b000, reg_index[2:0]};
      end else if (reg_index < 4'd13) begin
         phys = {2'b00, reg_index};
      end else begin
         phys = BANKED_BASE + {3'b000, bank_off, 1'b0} + {5'd0, ~reg_index[0]};
      end
   end

   always_comb begin
      dec           = '0;
      dec.mask      = '1;
      if (access_size == SIZE_BYTE) begin
         dec.mask = 32'h0000_00FF;
      end else if (access_size == SIZE_HALF) begin
         dec.mask = 32'h0000_FFFF;
      end
      case (action)
         ACT_READ_REG, ACT_WRITE_REG: begin
            dec.addr   = phys;
            dec.err    = phys_err;
            dec.rd_mem = ~phys_err & (action == ACT_READ_REG);
            dec.wr_mem = ~phys_err & (action == ACT_WRITE_REG);
         end
         ACT_READ_STAT: begin
            dec.rd_status = 1'b1;
         end
         ACT_WRITE_STAT: begin
            dec.wr_status = 1'b1;
         end
         ACT_READ_SAVED, ACT_WRITE_SAVED: begin
            dec.mask   = '1;
            dec.addr   = SAVED_BASE + {3'b000, bank} - 6'd1;
            dec.err    = (bank == BANK_USR) || (bank == BANK_NONE);
            dec.rd_mem = ~dec.err & (action == ACT_READ_SAVED);
            dec.wr_mem = ~dec.err & (action == ACT_WRITE_SAVED);
         end
         default: begin
            dec.err = 1'b1;
         end
      endcase
   end

endmodule

// ----- hdl/mode_banked_register_file_top.sv -----
// Flow: a request is decoded and its RAM entry read in S_IDLE, then merged, written back
//   and its result registered in S_READ; no new request is taken until S_IDLE returns,
//   and S_READ holds while a result waits in the output register.
// Reset: synchronous active high; all registers and saved status read 0 at once
//   through per-entry valid bits, no clearing pass; current status resets to 0.
// ----------------------------------------------------------------------------
// Mode-banked register file top level
// Read-modify-write register file over one RAM with mode bank decode.
// ----------------------------------------------------------------------------
module mode_banked_register_file_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // reg_index[3:0], access_size[5:4], write_data[37:6], pad
   input  logic [2:0]  req_tuser,  // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // read_data[31:0]
   output logic [0:0]  rsp_tuser   // access_error[0]
);
   import mbrf_pkg::*;

   state_type         state_ff, state_in;
   decode_type        dec_now, dec_ff, dec_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic [DATA_W-1:0] status_ff, status_in;
   logic [MEM_DEPTH-1:0] valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              accept, commit, out_free;
   logic [MEM_AW-1:0] ram_raddr;
   logic [DATA_W-1:0] ram_rdata, entry, merged, result;

   mbrf_decode u_decode (
      .action      (req_tuser),
      .reg_index   (req_tdata[3:0]),
      .access_size (req_tdata[5:4]),
      .mode        (status_ff[4:0]),
      .dec         (dec_now)
   );

   mbrf_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (commit & dec_ff.wr_mem),
      .wr_addr (dec_ff.addr),
      .wr_data (merged),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign accept   = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_READ:  commit     = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   assign ram_raddr = (state_ff == S_IDLE) ? dec_now.addr : dec_ff.addr;
   assign entry     = valid_ff[dec_ff.addr] ? ram_rdata : '0;
   assign merged    = (entry & ~dec_ff.mask) | (wdata_ff & dec_ff.mask);

   always_comb begin
      result = '0;
      if (dec_ff.rd_mem) begin
         result = entry & dec_ff.mask;
      end else if (dec_ff.rd_status) begin
         result = status_ff;
      end
   end

   always_comb begin
      dec_in       = accept ? dec_now : dec_ff;
      wdata_in     = accept ? req_tdata[37:6] : wdata_ff;
      status_in    = (commit && dec_ff.wr_status) ? wdata_ff : status_ff;
      valid_in     = valid_ff;
      if (commit && dec_ff.wr_mem) begin
         valid_in[dec_ff.addr] = 1'b1;
      end
      rsp_valid_in = commit | (rsp_valid_ff & ~rsp_tready);
      rsp_data_in  = commit ? result : rsp_data_ff;
      rsp_err_in   = commit ? dec_ff.err : rsp_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff      <= dec_in;
      wdata_ff    <= wdata_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ----- hdl/mbrf_checker.sv -----
// ----------------------------------------------------------------------------
// Mode-banked register file port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "mode_banked_register_file_top_defines.svh"

module mbrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   `MBRF_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")
   `MBRF_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `MBRF_ASSERT(a_err_zero, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0, "error with nonzero data")
   `MBRF_ASSERT(a_busy_after_accept, req_tvalid && req_tready |=> !req_tready, "accepted while busy")

endmodule

bind mode_banked_register_file_top mbrf_checker u_mbrf_checker (.*);
